>>> design/ela_pkg.sv
// Shared types and constants for the echo level averager.
// Used by every module of the block; no dependencies of its own.
package ela_pkg;

    // Window length default
    localparam int SAMPLES_DEFAULT = 10;

    // Field widths
    localparam int ECHO_W = 16;
    localparam int DIST_W = 17;
    localparam int SUM_W  = 23;
    localparam int CNT_W  = 7;
    localparam int REJ_W  = 8;
    localparam int LEN_W  = 10;
    localparam int CAP_W  = 16;
    localparam int LIM_W  = 8;
    localparam int PCT_W  = 7;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TANK_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_POINT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LIMIT = 3'd4;

    // Register reset values
    localparam logic [LEN_W-1:0] TANK_HEIGHT_RST = 10'd230;
    localparam logic [LEN_W-1:0] FULL_POINT_RST  = 10'd20;
    localparam logic [CAP_W-1:0] CAPACITY_RST    = 16'd40414;
    localparam logic [LIM_W-1:0] WARN_LIMIT_RST  = 8'd10;
    localparam logic [LIM_W-1:0] RESET_LIMIT_RST = 8'd20;

    // Reciprocal constants: x/10 for x < 2^21, x/100 for x < 2^17 and x < 2^23
    localparam int                DIV10_SHIFT   = 24;
    localparam logic [20:0]       DIV10_RCP     = 21'd1677722;
    localparam int                CM_SHIFT      = 24;
    localparam logic [17:0]       CM_RCP        = 18'd167773;
    localparam int                VOL_SHIFT     = 30;
    localparam logic [23:0]       VOL_RCP       = 24'd10737419;

    // Scale between cm and hundredths, and percent
    localparam logic [6:0]        HUNDRED       = 7'd100;

    // Front to back queue
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [LEN_W-1:0] tank_height;
        logic [LEN_W-1:0] full_point;
        logic [CAP_W-1:0] capacity;
        logic [LIM_W-1:0] warn_limit;
        logic [LIM_W-1:0] reset_limit;
    } cfg_t;

    // One classified reading handed from front to back
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              sample_valid;
        logic              window_done;
        logic [SUM_W-1:0]  sum;
        logic              warn;
        logic              reset_req;
    } entry_t;

    // One finished result
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              sample_valid;
        logic              window_done;
        logic [DIST_W-1:0] average;
        logic [PCT_W-1:0]  percent;
        logic [CAP_W-1:0]  volume;
        logic              warn;
        logic              reset_req;
    } result_t;

endpackage

>>> design/ela_queue.sv
// Short register queue between the front and back parts.
// Depends on ela_pkg for the entry type and depth.
module ela_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ela_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output ela_pkg::entry_t pop_data,
    output logic            empty
);

    localparam int DEPTH = ela_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ela_pkg::entry_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/ela_front.sv
// Front part: converts echo time to distance, gates it against the tank
// limits and keeps the window sum, valid count and reject count. Uses ela_pkg.
module ela_front #(
    parameter int SAMPLES_PER_WINDOW = ela_pkg::SAMPLES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ela_pkg::cfg_t               cfg,
    input  logic                        push,
    input  logic [ela_pkg::ECHO_W-1:0]  echo_time_us,
    output logic                        full,
    output logic                        q_push,
    output ela_pkg::entry_t             q_data,
    input  logic                        q_full
);

    localparam int DW = ela_pkg::DIST_W;
    localparam int SW = ela_pkg::SUM_W;
    localparam int CW = ela_pkg::CNT_W;
    localparam int RW = ela_pkg::REJ_W;

    logic           s1_valid_reg;
    logic [DW-1:0]  dist_reg;
    logic [SW-1:0]  sum_reg;
    logic [SW-1:0]  sum_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic [RW-1:0]  rej_reg;
    logic [RW-1:0]  rej_next;

    logic [20:0]    echo_x17;
    logic [41:0]    dist_prod;
    logic [DW-1:0]  dist_calc;
    logic [DW-1:0]  height_centi;
    logic [DW-1:0]  full_centi;
    logic           reject;
    logic [RW-1:0]  rej_inc;
    logic [CW-1:0]  cnt_inc;
    logic [SW-1:0]  sum_add;
    logic           win_done;
    logic           warn;
    logic           rst_req;

    assign full = s1_valid_reg;

    // distance = echo*17/10, the divide by ten through a reciprocal
    assign echo_x17  = {1'b0, echo_time_us, 4'b0000} + {5'b00000, echo_time_us};
    assign dist_prod = 42'(echo_x17) * 42'(ela_pkg::DIV10_RCP);
    assign dist_calc = dist_prod[ela_pkg::DIV10_SHIFT +: DW];

    // tank limits in hundredths of a cm
    assign height_centi = DW'(cfg.tank_height) * DW'(ela_pkg::HUNDRED);
    assign full_centi   = DW'(cfg.full_point) * DW'(ela_pkg::HUNDRED);
    assign reject       = (dist_reg > height_centi) || (dist_reg < full_centi);

    assign rej_inc  = (rej_reg == '1) ? rej_reg : rej_reg + 1'b1;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign sum_add  = sum_reg + SW'(dist_reg);
    assign win_done = !reject && (cnt_inc >= CW'(SAMPLES_PER_WINDOW));
    assign warn     = reject && (rej_inc > cfg.warn_limit);
    assign rst_req  = reject && (rej_inc > cfg.reset_limit);

    assign q_push = s1_valid_reg && !q_full;

    // classified entry
    always_comb
    begin
        q_data.distance     = dist_reg;
        q_data.sample_valid = !reject;
        q_data.window_done  = win_done;
        q_data.sum          = sum_add;
        q_data.warn         = warn;
        q_data.reset_req    = rst_req;
    end

    // window and error state update
    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        rej_next = rej_reg;
        if (q_push)
        begin
            if (reject)
            begin
                if (rst_req)
                begin
                    sum_next = '0;
                    cnt_next = '0;
                    rej_next = '0;
                end
                else
                begin
                    rej_next = rej_inc;
                end
            end
            else
            begin
                rej_next = '0;
                if (win_done)
                begin
                    sum_next = '0;
                    cnt_next = '0;
                end
                else
                begin
                    sum_next = sum_add;
                    cnt_next = cnt_inc;
                end
            end
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            rej_reg      <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (q_push)
            begin
                s1_valid_reg <= 1'b0;
            end
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            rej_reg <= rej_next;
        end
    end

    // distance register
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            dist_reg <= dist_calc;
        end
    end

endmodule

>>> design/ela_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Used by the back part for the percent full; uses ela_pkg widths.
module ela_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ela_pkg::DIST_W-1:0]  dividend,
    input  logic [ela_pkg::LEN_W-1:0]   divisor,
    output logic                        busy,
    output logic                        done,
    output logic [ela_pkg::DIST_W-1:0]  quotient
);

    localparam int QW  = ela_pkg::DIST_W;
    localparam int DVW = ela_pkg::LEN_W;
    localparam int IW  = $clog2(QW + 1);

    logic [IW-1:0]  iter_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [QW-1:0]  quo_reg;
    logic [DVW-1:0] rem_reg;
    logic [DVW-1:0] den_reg;
    logic [DVW:0]   trial;
    logic           fits;

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    // shift in the next dividend bit and try to subtract
    assign trial = {rem_reg, quo_reg[QW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                iter_reg <= IW'(QW);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == IW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[QW-2:0], fits};
            rem_reg <= fits ? DVW'(trial - {1'b0, den_reg}) : trial[DVW-1:0];
        end
    end

endmodule

>>> design/ela_back.sv
// Back part: for a closed window works out average, percent full and volume
// with a small sequencer, and for every item holds the result for the reader.
// Uses ela_pkg and the serial divider ela_div.
module ela_back #(
    parameter int SAMPLES_PER_WINDOW = ela_pkg::SAMPLES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ela_pkg::cfg_t    cfg,
    input  ela_pkg::entry_t  q_data,
    input  logic             q_empty,
    output logic             q_pop,
    output ela_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);

    localparam int DW = ela_pkg::DIST_W;
    localparam int SW = ela_pkg::SUM_W;
    localparam int LW = ela_pkg::LEN_W;
    localparam int PW = ela_pkg::PCT_W;
    localparam int CAPW = ela_pkg::CAP_W;

    // average through a reciprocal of the window length
    localparam int AVG_SHIFT = 29;
    localparam int AVG_RCP_W = AVG_SHIFT + 1;
    localparam logic [AVG_RCP_W-1:0] AVG_RCP =
        AVG_RCP_W'(((2 ** AVG_SHIFT) + SAMPLES_PER_WINDOW - 1) / SAMPLES_PER_WINDOW);
    localparam int AVG_PROD_W = SW + AVG_RCP_W;
    localparam int CM_PROD_W  = DW + 18;
    localparam int VOL_PROD_W = CAPW + PW;
    localparam int VOL_RCP_W  = VOL_PROD_W + 24;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_AVG_MUL  = 4'd1;
    localparam logic [3:0] ST_AVG      = 4'd2;
    localparam logic [3:0] ST_CM       = 4'd3;
    localparam logic [3:0] ST_DIV_GO   = 4'd4;
    localparam logic [3:0] ST_DIV_WAIT = 4'd5;
    localparam logic [3:0] ST_VOL_MUL  = 4'd6;
    localparam logic [3:0] ST_VOL_RCP  = 4'd7;
    localparam logic [3:0] ST_OUT      = 4'd8;

    logic [3:0]             state_reg;
    logic [3:0]             state_next;
    ela_pkg::entry_t        cur_reg;
    logic [AVG_PROD_W-1:0]  avg_prod_reg;
    logic [SW-1:0]          avg_reg;
    logic [CM_PROD_W-1:0]   cm_prod_reg;
    logic                   ok_reg;
    logic [PW-1:0]          pct_reg;
    logic [VOL_PROD_W-1:0]  vol_prod_reg;
    logic [VOL_RCP_W-1:0]   vol_rcp_reg;
    logic                   res_valid_reg;
    ela_pkg::result_t       res_reg;

    logic [SW-1:0]          height_centi;
    logic [SW-1:0]          full_centi;
    logic [LW-1:0]          avg_cm;
    logic [DW-1:0]          div_num;
    logic [LW-1:0]          div_den;
    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;
    logic [DW-1:0]          div_quo;
    logic                   res_load;

    assign height_centi = SW'(cfg.tank_height) * SW'(ela_pkg::HUNDRED);
    assign full_centi   = SW'(cfg.full_point) * SW'(ela_pkg::HUNDRED);
    assign avg_cm       = cm_prod_reg[ela_pkg::CM_SHIFT +: LW];
    assign div_num      = DW'(cfg.tank_height - avg_cm) * DW'(ela_pkg::HUNDRED);
    assign div_den      = cfg.tank_height - cfg.full_point;

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign div_start = (state_reg == ST_DIV_GO) && ok_reg;
    assign res_load  = (state_reg == ST_OUT) && (!res_valid_reg || pop);

    assign empty  = !res_valid_reg;
    assign result = res_reg;

    ela_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_data.window_done ? ST_AVG_MUL : ST_OUT;
                end
            end
            ST_AVG_MUL:  state_next = ST_AVG;
            ST_AVG:      state_next = ST_CM;
            ST_CM:       state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ok_reg ? ST_DIV_WAIT : ST_VOL_MUL;
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_VOL_MUL;
                end
            end
            ST_VOL_MUL:  state_next = ST_VOL_RCP;
            ST_VOL_RCP:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg     <= q_data;
            avg_reg     <= '0;
            pct_reg     <= '0;
            vol_rcp_reg <= '0;
        end
        if (state_reg == ST_AVG_MUL)
        begin
            avg_prod_reg <= AVG_PROD_W'(cur_reg.sum) * AVG_PROD_W'(AVG_RCP);
        end
        if (state_reg == ST_AVG)
        begin
            avg_reg <= avg_prod_reg[AVG_SHIFT +: SW];
        end
        // in-limits check and average in whole cm
        if (state_reg == ST_CM)
        begin
            cm_prod_reg <= CM_PROD_W'(avg_reg[DW-1:0]) * CM_PROD_W'(ela_pkg::CM_RCP);
            ok_reg      <= (cfg.tank_height > cfg.full_point) &&
                           (avg_reg >= full_centi) && (avg_reg <= height_centi);
        end
        if ((state_reg == ST_DIV_WAIT) && div_done)
        begin
            pct_reg <= div_quo[PW-1:0];
        end
        if (state_reg == ST_VOL_MUL)
        begin
            vol_prod_reg <= VOL_PROD_W'(cfg.capacity) * VOL_PROD_W'(pct_reg);
        end
        if (state_reg == ST_VOL_RCP)
        begin
            vol_rcp_reg <= VOL_RCP_W'(vol_prod_reg) * VOL_RCP_W'(ela_pkg::VOL_RCP);
        end
        // result register
        if (res_load)
        begin
            res_reg.distance     <= cur_reg.distance;
            res_reg.sample_valid <= cur_reg.sample_valid;
            res_reg.window_done  <= cur_reg.window_done;
            res_reg.average      <= avg_reg[DW-1:0];
            res_reg.percent      <= pct_reg;
            res_reg.volume       <= vol_rcp_reg[ela_pkg::VOL_SHIFT +: CAPW];
            res_reg.warn         <= cur_reg.warn;
            res_reg.reset_req    <= cur_reg.reset_req;
        end
    end

    // divider only starts for a sane tank and never while it is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (cfg.tank_height > cfg.full_point) && !div_busy)
        else $error("divider started out of limits or while busy");

    // a divider finish only lands while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    // an item that closes no window leaves the window figures at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && !cur_reg.window_done |-> (avg_reg == '0) && (pct_reg == '0))
        else $error("window figures set for an open window");

    // percent full never exceeds a full tank
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (pct_reg <= PW'(ela_pkg::HUNDRED)))
        else $error("percent full above one hundred");

endmodule

>>> design/echo_level_averager.sv
// Echo level averager top level: configuration registers, front part,
// queue and back part. Depends on ela_pkg, ela_front, ela_queue, ela_back.
//
// Ultrasonic tank level averager. Push one echo time (microseconds) per
// reading; pop one result per reading. The front part takes a new reading
// only once the last one has gone into the queue: it registers the distance,
// then gates it and updates the window. A reading that does not close a
// window passes the back part through its idle and output states into the
// result register; a reading that closes a window also passes the average,
// cm, 17-step serial divider for percent full (skipped when out of limits)
// and volume multiply steps. A two-entry queue lets the front keep
// accepting while the back works and the result register holds an unread
// result. Write the configuration registers only while the block is idle;
// register values are used as written.
module echo_level_averager #(
    parameter int SAMPLES_PER_WINDOW = ela_pkg::SAMPLES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write,
    input  logic [ela_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ela_pkg::CFG_DATA_W-1:0]  cfg_data,
    // readings
    input  logic                            push,
    output logic                            full,
    input  logic [ela_pkg::ECHO_W-1:0]      echo_time_us,
    // results
    output logic                            empty,
    input  logic                            pop,
    output logic [ela_pkg::DIST_W-1:0]      distance_centi,
    output logic                            sample_valid,
    output logic                            window_done,
    output logic [ela_pkg::DIST_W-1:0]      average_centi,
    output logic [ela_pkg::PCT_W-1:0]       percent_full,
    output logic [ela_pkg::CAP_W-1:0]       volume,
    output logic                            error_warning,
    output logic                            reset_request
);

    ela_pkg::cfg_t      cfg_reg;
    logic               q_push;
    ela_pkg::entry_t    q_wdata;
    logic               q_full;
    logic               q_pop;
    ela_pkg::entry_t    q_rdata;
    logic               q_empty;
    ela_pkg::result_t   result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tank_height <= ela_pkg::TANK_HEIGHT_RST;
            cfg_reg.full_point  <= ela_pkg::FULL_POINT_RST;
            cfg_reg.capacity    <= ela_pkg::CAPACITY_RST;
            cfg_reg.warn_limit  <= ela_pkg::WARN_LIMIT_RST;
            cfg_reg.reset_limit <= ela_pkg::RESET_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ela_pkg::CFG_TANK_HEIGHT: cfg_reg.tank_height <= cfg_data[ela_pkg::LEN_W-1:0];
                ela_pkg::CFG_FULL_POINT:  cfg_reg.full_point  <= cfg_data[ela_pkg::LEN_W-1:0];
                ela_pkg::CFG_CAPACITY:    cfg_reg.capacity    <= cfg_data[ela_pkg::CAP_W-1:0];
                ela_pkg::CFG_WARN_LIMIT:  cfg_reg.warn_limit  <= cfg_data[ela_pkg::LIM_W-1:0];
                ela_pkg::CFG_RESET_LIMIT: cfg_reg.reset_limit <= cfg_data[ela_pkg::LIM_W-1:0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    ela_front #(
        .SAMPLES_PER_WINDOW (SAMPLES_PER_WINDOW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .push         (push),
        .echo_time_us (echo_time_us),
        .full         (full),
        .q_push       (q_push),
        .q_data       (q_wdata),
        .q_full       (q_full)
    );

    ela_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    ela_back #(
        .SAMPLES_PER_WINDOW (SAMPLES_PER_WINDOW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_data  (q_rdata),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

    // result ports
    assign distance_centi = result.distance;
    assign sample_valid   = result.sample_valid;
    assign window_done    = result.window_done;
    assign average_centi  = result.average;
    assign percent_full   = result.percent;
    assign volume         = result.volume;
    assign error_warning  = result.warn;
    assign reset_request  = result.reset_req;

endmodule
